>>> hdl/mcag_pkg.sv
package mcag_pkg;

  // Widths of the configuration fields and of the stream payload.
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int MOSAIC_REG_W = 5;
  localparam int CUBE_REG_W   = 13;
  localparam int PIXEL_W      = 16;
  localparam int ADDR_W       = 32;
  localparam int BAND_OUT_W   = 8;
  localparam int OUT_DATA_W   = ADDR_W + BAND_OUT_W + PIXEL_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_ROWS   = 3'd4;

  // Layout codes.
  localparam logic LAYOUT_PLANAR      = 1'b0;
  localparam logic LAYOUT_INTERLEAVED = 1'b1;

endpackage

>>> hdl/mosaic_to_cube_address_gen_unit.sv
// Mosaic-to-cube address generator.
// An accepted input beat is registered in the first stage, then in the output stage.
// Throughput: one pixel per cycle unless m_tready stalls; the cell multiplier and
// the address multiplier sit in separate register stages, so neither limits the rate.
// Reset (rst, synchronous): layout planar, mosaic 5 x 5, cube 1 x 1, all position
// counters zero and the pipeline empty.
module mosaic_to_cube_address_gen_unit
  import mcag_pkg::*;
#(
  parameter int MAX_CUBE_SIDE   = 4096,
  parameter int MAX_MOSAIC_SIDE = 16,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input pixels.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIXEL_W-1:0]    s_tdata,   // [15:0] pixel_value
  // Output cube samples.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] cube_address, [39:32] band_index,
                                           // [55:40] sample_out
  output logic                  m_tlast    // frame_last
);

  localparam int PHASE_W = (MAX_MOSAIC_SIDE > 1) ? $clog2(MAX_MOSAIC_SIDE) : 1;
  localparam int CELL_W  = (MAX_CUBE_SIDE > 1) ? $clog2(MAX_CUBE_SIDE) : 1;
  localparam int BAND_W  = PHASE_W + MOSAIC_REG_W + 1;
  localparam logic [PIXEL_W-1:0] SAMPLE_MASK = PIXEL_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  // Configuration registers.
  logic                    layout_mode;
  logic [MOSAIC_REG_W-1:0] mosaic_cols;
  logic [MOSAIC_REG_W-1:0] mosaic_rows;
  logic [CUBE_REG_W-1:0]   cube_cols;
  logic [CUBE_REG_W-1:0]   cube_rows;

  // Position counters.
  logic [PHASE_W-1:0] phase_col, phase_col_next;
  logic [PHASE_W-1:0] phase_row, phase_row_next;
  logic [CELL_W-1:0]  cell_col, cell_col_next;
  logic [CELL_W-1:0]  cell_row, cell_row_next;

  // Clamped sizes.
  logic [MOSAIC_REG_W-1:0] mc, mr;
  logic [CUBE_REG_W-1:0]   cc, cr;

  logic wrap_pc, wrap_cc, wrap_pr, wrap_cr;
  logic [BAND_W-1:0] band;
  logic [ADDR_W-1:0] cell_idx;

  // First stage.
  logic                  s1_valid;
  logic                  s1_layout;
  logic [BAND_W-1:0]     s1_band;
  logic [ADDR_W-1:0]     s1_cell;
  logic [ADDR_W-1:0]     s1_ccr;
  logic [ADDR_W-1:0]     s1_mcr;
  logic [PIXEL_W-1:0]    s1_sample;
  logic                  s1_last;

  // Output stage.
  logic [ADDR_W-1:0]     out_addr;
  logic [BAND_OUT_W-1:0] out_band;
  logic [PIXEL_W-1:0]    out_sample;

  logic in_accept, s2_load;
  logic [ADDR_W-1:0] op_a, op_b, addend, product;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (mosaic_cols == '0) begin
      mc = MOSAIC_REG_W'(1);
    end else if (32'(mosaic_cols) > 32'(MAX_MOSAIC_SIDE)) begin
      mc = MOSAIC_REG_W'(MAX_MOSAIC_SIDE);
    end else begin
      mc = mosaic_cols;
    end
    if (mosaic_rows == '0) begin
      mr = MOSAIC_REG_W'(1);
    end else if (32'(mosaic_rows) > 32'(MAX_MOSAIC_SIDE)) begin
      mr = MOSAIC_REG_W'(MAX_MOSAIC_SIDE);
    end else begin
      mr = mosaic_rows;
    end
    if (cube_cols == '0) begin
      cc = CUBE_REG_W'(1);
    end else if (32'(cube_cols) > 32'(MAX_CUBE_SIDE)) begin
      cc = CUBE_REG_W'(MAX_CUBE_SIDE);
    end else begin
      cc = cube_cols;
    end
    if (cube_rows == '0) begin
      cr = CUBE_REG_W'(1);
    end else if (32'(cube_rows) > 32'(MAX_CUBE_SIDE)) begin
      cr = CUBE_REG_W'(MAX_CUBE_SIDE);
    end else begin
      cr = cube_rows;
    end
  end

  assign wrap_pc = (32'(phase_col) + 32'd1) >= 32'(mc);
  assign wrap_cc = (32'(cell_col) + 32'd1) >= 32'(cc);
  assign wrap_pr = (32'(phase_row) + 32'd1) >= 32'(mr);
  assign wrap_cr = (32'(cell_row) + 32'd1) >= 32'(cr);

  assign band = BAND_W'(phase_col) + BAND_W'(BAND_W'(phase_row) * BAND_W'(mc));
  assign cell_idx = ADDR_W'(cell_col) + ADDR_W'(ADDR_W'(cell_row) * ADDR_W'(cc));

  // Counters advance like an odometer: phase column, cell column, phase row, cell row.
  always_comb begin
    phase_col_next = phase_col;
    cell_col_next  = cell_col;
    phase_row_next = phase_row;
    cell_row_next  = cell_row;
    if (!wrap_pc) begin
      phase_col_next = phase_col + PHASE_W'(1);
    end else begin
      phase_col_next = '0;
      if (!wrap_cc) begin
        cell_col_next = cell_col + CELL_W'(1);
      end else begin
        cell_col_next = '0;
        if (!wrap_pr) begin
          phase_row_next = phase_row + PHASE_W'(1);
        end else begin
          phase_row_next = '0;
          if (!wrap_cr) begin
            cell_row_next = cell_row + CELL_W'(1);
          end else begin
            cell_row_next = '0;
          end
        end
      end
    end
  end

  assign s2_load   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || s2_load;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode <= LAYOUT_PLANAR;
      mosaic_cols <= MOSAIC_REG_W'(5);
      mosaic_rows <= MOSAIC_REG_W'(5);
      cube_cols   <= CUBE_REG_W'(1);
      cube_rows   <= CUBE_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYOUT_MODE: layout_mode <= cfg_data[0];
        REG_MOSAIC_COLS: mosaic_cols <= cfg_data[MOSAIC_REG_W-1:0];
        REG_MOSAIC_ROWS: mosaic_rows <= cfg_data[MOSAIC_REG_W-1:0];
        REG_CUBE_COLS:   cube_cols   <= cfg_data[CUBE_REG_W-1:0];
        REG_CUBE_ROWS:   cube_rows   <= cfg_data[CUBE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_col <= '0;
      cell_col  <= '0;
      phase_row <= '0;
      cell_row  <= '0;
    end else if (in_accept) begin
      phase_col <= phase_col_next;
      cell_col  <= cell_col_next;
      phase_row <= phase_row_next;
      cell_row  <= cell_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_layout <= layout_mode;
      s1_band   <= band;
      s1_cell   <= cell_idx;
      s1_ccr    <= ADDR_W'(ADDR_W'(cc) * ADDR_W'(cr));
      s1_mcr    <= ADDR_W'(ADDR_W'(mc) * ADDR_W'(mr));
      s1_sample <= s_tdata & SAMPLE_MASK;
      s1_last   <= wrap_pc && wrap_cc && wrap_pr && wrap_cr;
    end
  end

  // Planar: band * (cube area) + cell. Interleaved: cell * (mosaic area) + band.
  always_comb begin
    if (s1_layout == LAYOUT_INTERLEAVED) begin
      op_a   = s1_cell;
      op_b   = s1_mcr;
      addend = ADDR_W'(s1_band);
    end else begin
      op_a   = ADDR_W'(s1_band);
      op_b   = s1_ccr;
      addend = s1_cell;
    end
    product = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_addr   <= product + addend;
      out_band   <= s1_band[BAND_OUT_W-1:0];
      out_sample <= s1_sample;
      m_tlast    <= s1_last;
    end
  end

  assign m_tdata = {out_sample, out_band, out_addr};

endmodule

>>> sim/mcag_cube_checker.sv
module mcag_cube_checker
  import mcag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [PIXEL_W-1:0]    s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOSAIC_SIDE_MAX = 16;
  localparam int CUBE_SIDE_MAX   = 4096;

  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    logic [BAND_OUT_W-1:0] band;
    logic [PIXEL_W-1:0]    sample;
    logic                  last;
  } cube_beat_t;

  // Register copies.
  logic                    layout;
  logic [MOSAIC_REG_W-1:0] mos_cols, mos_rows;
  logic [CUBE_REG_W-1:0]   cub_cols, cub_rows;

  // Position counters.
  int unsigned phase_c, cell_c, phase_r, cell_r;

  cube_beat_t cube_q[$];

  function automatic longint unsigned clamp_side(input int unsigned v, input int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Computes the cube placement of one pixel and advances the counters in raster order.
  function automatic cube_beat_t place_pixel(input logic [PIXEL_W-1:0] px);
    longint unsigned mc, mr, cc, cr, band, cell_idx, addr;
    bit wrap_pc, wrap_cc, wrap_pr, wrap_cr;
    cube_beat_t res;
    mc   = clamp_side(mos_cols, MOSAIC_SIDE_MAX);
    mr   = clamp_side(mos_rows, MOSAIC_SIDE_MAX);
    cc   = clamp_side(cub_cols, CUBE_SIDE_MAX);
    cr   = clamp_side(cub_rows, CUBE_SIDE_MAX);
    band = longint'(phase_c) + longint'(phase_r) * mc;
    cell_idx = longint'(cell_c) + longint'(cell_r) * cc;
    if (layout == LAYOUT_INTERLEAVED) addr = cell_idx * (mc * mr) + band;
    else addr = band * (cc * cr) + cell_idx;
    wrap_pc = phase_c + 1 >= mc;
    wrap_cc = cell_c + 1 >= cc;
    wrap_pr = phase_r + 1 >= mr;
    wrap_cr = cell_r + 1 >= cr;
    res.addr   = addr[ADDR_W-1:0];
    res.band   = band[BAND_OUT_W-1:0];
    res.sample = px;
    res.last   = wrap_pc && wrap_cc && wrap_pr && wrap_cr;
    // Each counter only moves when every faster counter wraps.
    if (!wrap_pc) begin
      phase_c++;
    end else begin
      phase_c = 0;
      if (!wrap_cc) begin
        cell_c++;
      end else begin
        cell_c = 0;
        if (!wrap_pr) begin
          phase_r++;
        end else begin
          phase_r = 0;
          cell_r  = wrap_cr ? 0 : cell_r + 1;
        end
      end
    end
    return res;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin : watch
    cube_beat_t want, got;
    bit bad;
    if (rst) begin
      layout   = LAYOUT_PLANAR;
      mos_cols = 5;
      mos_rows = 5;
      cub_cols = 1;
      cub_rows = 1;
      phase_c  = 0;
      cell_c   = 0;
      phase_r  = 0;
      cell_r   = 0;
      cube_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LAYOUT_MODE: layout   = cfg_data[0];
          REG_MOSAIC_COLS: mos_cols = cfg_data[MOSAIC_REG_W-1:0];
          REG_MOSAIC_ROWS: mos_rows = cfg_data[MOSAIC_REG_W-1:0];
          REG_CUBE_COLS:   cub_cols = cfg_data[CUBE_REG_W-1:0];
          REG_CUBE_ROWS:   cub_rows = cfg_data[CUBE_REG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) cube_q.push_back(place_pixel(s_tdata));
      if (m_tvalid && m_tready) begin
        got.addr   = m_tdata[ADDR_W-1:0];
        got.band   = m_tdata[ADDR_W +: BAND_OUT_W];
        got.sample = m_tdata[ADDR_W+BAND_OUT_W +: PIXEL_W];
        got.last   = m_tlast;
        if (cube_q.size() == 0) begin
          $display("%0t: output beat with nothing expected: addr %h band %h sample %h last %b",
                   $time, got.addr, got.band, got.sample, got.last);
          errors++;
        end else begin
          want = cube_q.pop_front();
          bad  = 0;
          if (got.addr !== want.addr) begin
            $display("%0t: cube_address expected %h actual %h", $time, want.addr, got.addr);
            bad = 1;
          end
          if (got.band !== want.band) begin
            $display("%0t: band_index expected %h actual %h", $time, want.band, got.band);
            bad = 1;
          end
          if (got.sample !== want.sample) begin
            $display("%0t: sample_out expected %h actual %h", $time, want.sample, got.sample);
            bad = 1;
          end
          if (got.last !== want.last) begin
            $display("%0t: frame_last expected %b actual %b", $time, want.last, got.last);
            bad = 1;
          end
          if (bad) errors++;
        end
      end
    end
    pending <= cube_q.size();
  end

endmodule

>>> sim/tb_top.sv
module tb_top
  import mcag_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CALM_FROM    = 1500;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIXEL_W-1:0]    s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  int errors, pending;
  int cycle_cnt = 0;
  bit gaps_on  = 1'b1;
  bit hold_arm = 1'b0;

  always #5 clk = ~clk;

  mosaic_to_cube_address_gen_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  mcag_cube_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("mosaic_to_cube_address_gen_unit: mismatch");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off so the pipeline backs up.
  initial begin : sink
    int n;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_arm && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 20);
        m_tready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Leaves cfg_valid high; the caller lowers it after the last write of a group.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Leaves s_tvalid high so back-to-back pixels stream without a bubble.
  task automatic push_pixel(input logic [PIXEL_W-1:0] px);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering pixels and waits until every placed pixel has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_mosaic_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(16);
      2:       return CFG_DATA_W'($urandom_range(17, 31));
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cube_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(4096);
      2:       return CFG_DATA_W'($urandom_range(4097, 8191));
      3:       return CFG_DATA_W'($urandom_range(1, 4096));
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic retune();
    if ($urandom_range(0, 1))
      cfg_write(REG_LAYOUT_MODE, $urandom_range(0, 1) ? CFG_DATA_W'(LAYOUT_INTERLEAVED)
                                                      : CFG_DATA_W'(LAYOUT_PLANAR));
    if ($urandom_range(0, 1)) cfg_write(REG_MOSAIC_COLS, pick_mosaic_side());
    if ($urandom_range(0, 1)) cfg_write(REG_MOSAIC_ROWS, pick_mosaic_side());
    if ($urandom_range(0, 1)) cfg_write(REG_CUBE_COLS, pick_cube_side());
    if ($urandom_range(0, 1)) cfg_write(REG_CUBE_ROWS, pick_cube_side());
    if ($urandom_range(0, 5) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int sent, burst, phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: 5 x 5 mosaic, 1 x 1 cube, planar.
    push_pixel(16'h0000);
    push_pixel(16'hFFFF);
    push_pixel(16'hA5A5);
    drain();

    // Shrink the mosaic mid-frame so the column phase sits past its limit,
    // then walk the row phase up with a one-pixel-wide pattern.
    cfg_write(REG_LAYOUT_MODE, CFG_DATA_W'(LAYOUT_INTERLEAVED));
    cfg_write(REG_MOSAIC_COLS, CFG_DATA_W'(1));
    cfg_write(REG_MOSAIC_ROWS, CFG_DATA_W'(16));
    cfg_write(REG_CUBE_COLS, CFG_DATA_W'(1));
    cfg_write(REG_CUBE_ROWS, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    repeat (12) push_pixel(PIXEL_W'($urandom));
    drain();

    // Widest mosaic and largest cube: a high band index lands in the top address bits.
    cfg_write(REG_MOSAIC_COLS, CFG_DATA_W'(16));
    cfg_write(REG_CUBE_COLS, CFG_DATA_W'(4096));
    cfg_write(REG_CUBE_ROWS, CFG_DATA_W'(4096));
    cfg_write(REG_LAYOUT_MODE, CFG_DATA_W'(LAYOUT_PLANAR));
    cfg_valid <= 1'b0;
    push_pixel(16'h8001);
    push_pixel(16'h7FFE);
    drain();

    // Zero and oversized sizes are clamped; writes to unused indexes do nothing.
    cfg_write(REG_MOSAIC_COLS, '0);
    cfg_write(REG_MOSAIC_ROWS, CFG_DATA_W'(31));
    cfg_write(REG_CUBE_COLS, '0);
    cfg_write(REG_CUBE_ROWS, CFG_DATA_W'(8191));
    cfg_write(REG_UNUSED_LO, '1);
    cfg_write(REG_UNUSED_HI, '1);
    cfg_valid <= 1'b0;
    push_pixel(16'h00FF);
    push_pixel(16'hFF00);
    drain();

    // A 1 x 1 pattern on a 1 x 1 cube: every pixel ends a frame.
    cfg_write(REG_MOSAIC_COLS, CFG_DATA_W'(1));
    cfg_write(REG_MOSAIC_ROWS, CFG_DATA_W'(1));
    cfg_write(REG_CUBE_COLS, CFG_DATA_W'(1));
    cfg_write(REG_CUBE_ROWS, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    repeat (3) push_pixel(PIXEL_W'($urandom));
    drain();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      retune();
      gaps_on = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      // The hold-off burst is long enough that pixels are still offered while the sink waits.
      if (phase == 3) begin
        gaps_on  = 1'b0;
        hold_arm = 1'b1;
        burst    = HOLD_CYCLES;
      end else begin
        burst = $urandom_range(20, 120);
      end
      repeat (burst) push_pixel(PIXEL_W'($urandom));
      sent += burst;
      phase++;
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("mosaic_to_cube_address_gen_unit: match");
    else
      $display("mosaic_to_cube_address_gen_unit: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
hdl/mcag_pkg.sv
hdl/mosaic_to_cube_address_gen_unit.sv
sim/mcag_cube_checker.sv
sim/tb_top.sv
